>>> design/pced_pkg.sv
// ----------------------------------------------------------------------------
// pced_pkg
// Shared types and constants for the pin change event detector: request and
// event payloads, opcodes, and the control and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package pced_pkg;

    // width of the pin masks and of the level vector
    localparam int MASK_W = 30;
    localparam int PIN_W  = 5;

    // default number of pins watched
    localparam int PCED_PIN_COUNT = 30;

    // request opcodes
    localparam logic [1:0] OP_POLL   = 2'd0;
    localparam logic [1:0] OP_ARM    = 2'd1;
    localparam logic [1:0] OP_DISARM = 2'd2;

    // one request item
    typedef struct packed {
        logic [1:0]        opcode;
        logic [PIN_W-1:0]  pin_index;
        logic              invert_pin;
        logic              has_handler;
        logic [MASK_W-1:0] pin_levels;
    } cmd_t;

    // one event item
    typedef struct packed {
        logic [PIN_W-1:0] event_pin;
        logic             event_active;
        logic             last_event;
    } evt_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
        logic emit;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic is_poll;
        logic pending_any;
        logic hit;
        logic last;
        logic slot_free;
    } sts_t;

endpackage

>>> design/pced_ctrl.sv
// ----------------------------------------------------------------------------
// pced_ctrl
// Controller: takes requests while idle and walks the pin scan of a poll,
// issuing one step per pin and an emit for each pin that raised an event.
// ----------------------------------------------------------------------------
module pced_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  pced_pkg::sts_t sts,
    output pced_pkg::ctl_t ctl
);
    import pced_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // request acceptance and scan commands
    always_comb
    begin
        cmd_stall  = (state_reg != ST_IDLE);
        ctl.accept = cmd_valid && (state_reg == ST_IDLE);
        ctl.step   = (state_reg == ST_SCAN) && sts.pending_any && (!sts.hit || sts.slot_free);
        ctl.emit   = (state_reg == ST_SCAN) && sts.pending_any && sts.hit && sts.slot_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.accept && sts.is_poll)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!sts.pending_any)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/pced_dp.sv
// ----------------------------------------------------------------------------
// pced_dp
// Datapath: the four pin masks, the pending event vector of a poll, the scan
// index and the event output register.
// ----------------------------------------------------------------------------
module pced_dp #(
    parameter int PIN_COUNT = pced_pkg::PCED_PIN_COUNT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pced_pkg::cmd_t cmd,
    input  pced_pkg::ctl_t ctl,
    output pced_pkg::sts_t sts,
    output logic           evt_valid,
    input  logic           evt_stall,
    output pced_pkg::evt_t evt
);
    import pced_pkg::*;

    // pins that exist: below both the pin count and the mask width
    localparam logic [PIN_W:0] PIN_LIMIT =
        (PIN_W+1)'((PIN_COUNT < MASK_W) ? PIN_COUNT : MASK_W);
    localparam logic [MASK_W-1:0] VALID_MASK =
        (PIN_COUNT >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << PIN_COUNT) - 64'd1);

    logic [MASK_W-1:0] interest_reg;
    logic [MASK_W-1:0] invert_reg;
    logic [MASK_W-1:0] reported_reg;
    logic [MASK_W-1:0] handler_reg;
    logic [MASK_W-1:0] pending_reg;
    logic [MASK_W-1:0] active_reg;
    logic [PIN_W-1:0]  idx_reg;
    logic              evt_valid_reg;
    evt_t              evt_reg;

    logic              pin_ok;
    logic [MASK_W-1:0] pin_sel;
    logic              arm_active;
    logic [MASK_W-1:0] active_now;
    logic [MASK_W-1:0] changed;
    logic [MASK_W-1:0] idx_sel;
    logic [MASK_W-1:0] rest;

    // decode of the addressed pin
    always_comb
    begin
        pin_ok     = ({1'b0, cmd.pin_index} < PIN_LIMIT);
        pin_sel    = pin_ok ? (MASK_W'(1) << cmd.pin_index) : '0;
        arm_active = (|(cmd.pin_levels & pin_sel)) ^ cmd.invert_pin;
    end

    // active levels and changed armed pins for a poll
    always_comb
    begin
        active_now = (cmd.pin_levels ^ invert_reg) & VALID_MASK;
        changed    = (active_now ^ reported_reg) & interest_reg & VALID_MASK;
    end

    // scan position and events still to come after it
    always_comb
    begin
        idx_sel = MASK_W'(1) << idx_reg;
        rest    = pending_reg & ~idx_sel;
    end

    assign sts.is_poll     = (cmd.opcode == OP_POLL);
    assign sts.pending_any = |pending_reg;
    assign sts.hit         = |(pending_reg & idx_sel);
    assign sts.last        = (rest == '0);
    assign sts.slot_free   = !evt_valid_reg || !evt_stall;

    // pin masks and scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interest_reg <= '0;
            invert_reg   <= '0;
            reported_reg <= '0;
            handler_reg  <= '0;
            pending_reg  <= '0;
            idx_reg      <= '0;
        end
        else if (ctl.accept)
        begin
            unique case (cmd.opcode)
                OP_POLL:
                begin
                    reported_reg <= (reported_reg & ~changed) | (active_now & changed);
                    pending_reg  <= changed & handler_reg;
                    idx_reg      <= '0;
                end
                OP_ARM:
                begin
                    interest_reg <= interest_reg | pin_sel;
                    invert_reg   <= cmd.invert_pin ? (invert_reg | pin_sel)
                                                   : (invert_reg & ~pin_sel);
                    handler_reg  <= cmd.has_handler ? (handler_reg | pin_sel)
                                                    : (handler_reg & ~pin_sel);
                    reported_reg <= arm_active ? (reported_reg & ~pin_sel)
                                               : (reported_reg | pin_sel);
                end
                OP_DISARM:
                begin
                    interest_reg <= interest_reg & ~pin_sel;
                    handler_reg  <= handler_reg & ~pin_sel;
                end
                default:
                begin
                    pending_reg <= pending_reg;
                end
            endcase
        end
        else if (ctl.step)
        begin
            if (ctl.emit)
            begin
                pending_reg <= rest;
            end
            idx_reg <= idx_reg + PIN_W'(1);
        end
    end

    // active levels of the poll being scanned
    always_ff @(posedge clk)
    begin
        if (ctl.accept && sts.is_poll)
        begin
            active_reg <= active_now;
        end
    end

    // event output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            evt_valid_reg <= 1'b1;
        end
        else if (!evt_stall)
        begin
            evt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            evt_reg.event_pin    <= idx_reg;
            evt_reg.event_active <= |(active_reg & idx_sel);
            evt_reg.last_event   <= sts.last;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

endmodule

>>> design/pin_change_event_detector_core.sv
// ----------------------------------------------------------------------------
// pin_change_event_detector_core
// Watches a vector of pin levels and reports active-state changes of armed
// pins as a stream of events.
// ----------------------------------------------------------------------------
// Arm and disarm requests leave the block idle, so it is ready again in the
// next cycle. A poll request compares all pins at once in its accept cycle, then
// a scan index walks the pins one per cycle, except while the event output is
// stalled, from pin 0 up to the highest pin that raised an event, handing one
// event per hit pin to the output register; the block takes no new request
// until the scan is through. Events come out in ascending pin order, the last
// one of a poll flagged by last_event.
// ----------------------------------------------------------------------------
module pin_change_event_detector_core #(
    parameter int PIN_COUNT = pced_pkg::PCED_PIN_COUNT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  pced_pkg::cmd_t cmd,
    output logic           evt_valid,
    input  logic           evt_stall,
    output pced_pkg::evt_t evt
);
    import pced_pkg::*;

    ctl_t ctl;
    sts_t sts;

    // request sequencing
    pced_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // masks, scan and event register
    pced_dp #(
        .PIN_COUNT (PIN_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .sts       (sts),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

    // no request is taken while a poll still has events to hand out
    a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        sts.pending_any |-> cmd_stall)
        else $error("request accepted while poll events pending");

    // an emitted event shows up on the output in the next cycle
    a_emit_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |=> evt_valid)
        else $error("emitted event not presented");

    // the event flagged last leaves nothing pending
    a_last_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit && sts.last) |=> !sts.pending_any)
        else $error("events remain after last event");

endmodule
